[hdl/nbs_pkg.sv]
`default_nettype none

package nbs_pkg;

  localparam int SET_W   = 16;
  localparam int SRC_W   = 4;
  localparam int SYM_W   = 7;
  localparam int ACT_W   = 2;
  localparam int ROW_AW  = SYM_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_SYMBOLS_DEF = 'h80;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 2'd1;

  // One row write into the transition store; addr is {backward, symbol}.
  typedef struct packed {
    logic              en;
    logic [SRC_W-1:0]  lane;
    logic [ROW_AW-1:0] addr;
    logic [SET_W-1:0]  data;
  } row_wr_t;

  // Mask of the state bits that exist in an automaton of n states.
  function automatic logic [SET_W-1:0] state_mask(int n);
    logic [SET_W-1:0] m;
    m = '0;
    for (int i = 0; i < SET_W; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/nbs_if.sv]
`default_nettype none

interface nbs_in_if;
  logic                         valid;
  logic                         ready;
  logic [nbs_pkg::ACT_W-1:0]    action;
  logic                         backward;
  logic [nbs_pkg::SRC_W-1:0]    source_state;
  logic [nbs_pkg::SYM_W-1:0]    symbol;
  logic [nbs_pkg::SET_W-1:0]    row_mask;

  modport source (output valid, action, backward, source_state, symbol, row_mask,
                  input ready);
  modport sink (input valid, action, backward, source_state, symbol, row_mask,
                output ready);
endinterface

interface nbs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         at_start;
  logic                         accepting;
  logic [nbs_pkg::SET_W-1:0]    active_set;

  modport source (output valid, at_start, accepting, active_set, input ready);
  modport sink (input valid, at_start, accepting, active_set, output ready);
endinterface

interface nbs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nbs_pkg::CFG_IDX_W-1:0] index;
  logic [nbs_pkg::SET_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/nbs_row_store.sv]
`default_nettype none

// Transition store: one 16-bit lane memory per source state, all lanes
// addressed by {backward, symbol}. Cleared by a sweep after reset.
module nbs_row_store #(
  parameter int NUM_STATES  = nbs_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = nbs_pkg::NUM_SYMBOLS_DEF,
  localparam int LANES = (NUM_STATES < nbs_pkg::SET_W) ? NUM_STATES : nbs_pkg::SET_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire nbs_pkg::row_wr_t                 wr,
  input  wire logic                             rd_en,
  input  wire logic [nbs_pkg::ROW_AW-1:0]       rd_addr,
  output logic [LANES-1:0][nbs_pkg::SET_W-1:0]  rd_data,
  output logic                                  clearing
);

  localparam int SYM_AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int AW     = SYM_AW + 1;
  localparam int DEPTH  = 1 << AW;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  // Keep the direction bit on top, drop unused symbol bits.
  assign wa = {wr.addr[nbs_pkg::ROW_AW-1], wr.addr[SYM_AW-1:0]};
  assign ra = {rd_addr[nbs_pkg::ROW_AW-1], rd_addr[SYM_AW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == {AW{1'b1}}) clearing <= 1'b0;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [nbs_pkg::SET_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_addr] <= '0;
      end else if (wr.en && (wr.lane == nbs_pkg::SRC_W'(l))) begin
        mem[wa] <= wr.data;
      end
      if (rd_en) rd_data[l] <= mem[ra];
    end
  end

endmodule

`default_nettype wire

[hdl/nfa_bitset_step_engine.sv]
`default_nettype none

// Bit-parallel NFA step engine. Each beat on items writes one transition
// row, loads the active state set, or steps the set on one symbol, and
// gives exactly one beat on results: the active set after the item, whether
// it holds start_state and whether it meets accept_mask. Items are taken one
// per cycle, back to back, unless the store sweep or a stalled result holds
// them off; a result beat is offered once the store read, launched at the
// accepting edge, has returned the rows and the OR of the active rows has
// landed in the output register. A stalled result holds one item in the
// output register and one in the read stage before items are pushed back.
// The store keeps one lane memory per source state, so a step reads the rows
// of all states for its symbol in a single access and a row written by one
// item is seen by the very next step. After reset the store is swept to
// zero, one address per cycle, over every one of its addresses (256 with
// the default sizes); items are held off during that sweep, while
// configuration writes are taken at any time. Mask bits for states at or
// above NUM_STATES are dropped; a step on a symbol at or above NUM_SYMBOLS
// empties the set; action code 3 changes nothing and reports the set.
module nfa_bitset_step_engine #(
  parameter int NUM_STATES  = nbs_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = nbs_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  nbs_in_if.sink      items,
  nbs_out_if.source   results,
  nbs_cfg_if.sink     cfg
);

  localparam int LANES = (NUM_STATES < nbs_pkg::SET_W) ? NUM_STATES : nbs_pkg::SET_W;
  localparam logic [nbs_pkg::SET_W-1:0] VALID_MASK = nbs_pkg::state_mask(NUM_STATES);

  // Configuration registers.
  logic [nbs_pkg::SRC_W-1:0] start_state;
  logic [nbs_pkg::SET_W-1:0] accept_mask;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
      accept_mask <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        nbs_pkg::REG_START_STATE: start_state <= cfg.data[nbs_pkg::SRC_W-1:0];
        nbs_pkg::REG_ACCEPT_MASK: accept_mask <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline control: stage 1 holds the item whose store read is in flight.
  logic                          clearing;
  logic                          accept;
  logic                          s1_valid;
  logic                          s1_adv;
  logic [nbs_pkg::ACT_W-1:0]     s1_action;
  logic                          s1_sym_ok;
  logic [nbs_pkg::SET_W-1:0]     s1_mask;
  logic [LANES-1:0][nbs_pkg::SET_W-1:0] rd_data;
  nbs_pkg::row_wr_t              wr;
  logic                          sym_ok;
  logic                          src_ok;

  // Advance stage 1 whenever the output register is free or being drained.
  assign s1_adv       = !results.valid || results.ready;
  assign items.ready  = !clearing && (!s1_valid || s1_adv);
  assign accept       = items.valid && items.ready;

  assign sym_ok = 32'(items.symbol) < NUM_SYMBOLS;
  assign src_ok = 32'(items.source_state) < NUM_STATES;

  // Row writes go to the store on the accepting edge, so the next item's
  // read already sees them.
  always_comb begin
    wr.en   = accept && (items.action == nbs_pkg::ACT_WRITE) && sym_ok && src_ok;
    wr.lane = items.source_state;
    wr.addr = {items.backward, items.symbol};
    wr.data = items.row_mask & VALID_MASK;
  end

  nbs_row_store #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (accept),
    .rd_addr  ({items.backward, items.symbol}),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload of stage 1 needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= items.action;
      s1_sym_ok <= sym_ok;
      s1_mask   <= items.row_mask;
    end
  end

  // Stage 1: combine the rows of every active state, then pick the next set by action.
  logic [nbs_pkg::SET_W-1:0] active;
  logic [nbs_pkg::SET_W-1:0] step_set;
  logic [nbs_pkg::SET_W-1:0] active_next;
  logic                      at_start_next;

  always_comb begin
    step_set = '0;
    for (int l = 0; l < LANES; l++) begin
      if (active[l]) step_set = step_set | rd_data[l];
    end
    if (!s1_sym_ok) step_set = '0;

    case (s1_action)
      nbs_pkg::ACT_LOAD: active_next = s1_mask & VALID_MASK;
      nbs_pkg::ACT_STEP: active_next = step_set & VALID_MASK;
      default:           active_next = active;
    endcase

    at_start_next = (32'(start_state) < NUM_STATES) && active_next[start_state];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= '0;
      results.valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      active        <= active_next;
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  // Output register payload; hold while the beat is stalled.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      results.active_set <= active_next;
      results.at_start   <= at_start_next;
      results.accepting  <= (active_next & accept_mask) != '0;
    end
  end

  // No item may enter while the store is being swept.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !items.ready)
    else $error("item accepted during store clear");

  // A stalled item in stage 1 is never dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stage 1 item lost while stalled");

  // A step on a symbol outside the store empties the active set.
  a_bad_sym_empties: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && (s1_action == nbs_pkg::ACT_STEP) && !s1_sym_ok)
    |=> (active == '0))
    else $error("step on missing symbol left states active");

  // The active set never holds states beyond the automaton.
  a_active_in_range: assert property (@(posedge clk) disable iff (rst)
    (active & ~VALID_MASK) == '0)
    else $error("active set holds out-of-range state");

endmodule

`default_nettype wire

[bench/nbs_step_checker.sv]
`default_nettype none

// Watch the item, result and register channels, track the automaton and
// compare every result beat against the oldest predicted report.
module nbs_step_checker #(
  parameter int NUM_STATES  = nbs_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = nbs_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  nbs_in_if         items,
  nbs_out_if        results,
  nbs_cfg_if        cfg,
  output int        mismatches,
  output int        backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [nbs_pkg::SET_W-1:0] LIVE_STATES =
    (NUM_STATES >= nbs_pkg::SET_W) ? {nbs_pkg::SET_W{1'b1}} :
    nbs_pkg::SET_W'((32'd1 << NUM_STATES) - 32'd1);

  typedef struct packed {
    logic                      at_start;
    logic                      accepting;
    logic [nbs_pkg::SET_W-1:0] active_set;
  } nfa_report_t;

  logic [nbs_pkg::SET_W-1:0] trans_rows [2][NUM_STATES][NUM_SYMBOLS];
  logic [nbs_pkg::SET_W-1:0] active_now;
  logic [nbs_pkg::SRC_W-1:0] start_reg;
  logic [nbs_pkg::SET_W-1:0] accept_reg;
  nfa_report_t               pending_reports[$];
  nfa_report_t               got;
  nfa_report_t               want;
  int                        fail_count = 0;
  int                        queued = 0;

  assign mismatches = fail_count;
  assign backlog    = queued;

  // Advance the automaton by one item and return what the block reports.
  function automatic nfa_report_t apply_item(
    input logic [nbs_pkg::ACT_W-1:0] act,
    input logic                      bwd,
    input logic [nbs_pkg::SRC_W-1:0] src,
    input logic [nbs_pkg::SYM_W-1:0] sym,
    input logic [nbs_pkg::SET_W-1:0] mask
  );
    nfa_report_t               r;
    logic [nbs_pkg::SET_W-1:0] nxt;
    case (act)
      nbs_pkg::ACT_WRITE: begin
        if (int'(src) < NUM_STATES && int'(sym) < NUM_SYMBOLS)
          trans_rows[bwd][src][sym] = mask & LIVE_STATES;
      end
      nbs_pkg::ACT_LOAD: begin
        active_now = mask & LIVE_STATES;
      end
      nbs_pkg::ACT_STEP: begin
        nxt = '0;
        if (int'(sym) < NUM_SYMBOLS) begin
          for (int s = 0; s < NUM_STATES && s < nbs_pkg::SET_W; s++) begin
            if (active_now[s]) nxt = nxt | trans_rows[bwd][s][sym];
          end
        end
        active_now = nxt & LIVE_STATES;
      end
      default: ;
    endcase
    r.at_start   = (int'(start_reg) < NUM_STATES && int'(start_reg) < nbs_pkg::SET_W) ?
                   active_now[start_reg] : 1'b0;
    r.accepting  = |(active_now & accept_reg);
    r.active_set = active_now;
    return r;
  endfunction

  task automatic flag(input string field, input logic [nbs_pkg::SET_W-1:0] exp_v,
                      input logic [nbs_pkg::SET_W-1:0] act_v);
    fail_count++;
    $display("%0t: %s expected %h, got %h", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (trans_rows[d, s, y]) trans_rows[d][s][y] = '0;
      active_now = '0;
      start_reg  = '0;
      accept_reg = '0;
      pending_reports.delete();
      queued     = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          nbs_pkg::REG_START_STATE: start_reg = cfg.data[nbs_pkg::SRC_W-1:0];
          nbs_pkg::REG_ACCEPT_MASK: accept_reg = cfg.data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        got.at_start   = results.at_start;
        got.accepting  = results.accepting;
        got.active_set = results.active_set;
        if (pending_reports.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing pending, expected none, got set %h",
                   $time, got.active_set);
        end else begin
          want = pending_reports.pop_front();
          if (got.active_set != want.active_set)
            flag("active_set", want.active_set, got.active_set);
          if (got.at_start != want.at_start)
            flag("at_start", nbs_pkg::SET_W'(want.at_start),
                 nbs_pkg::SET_W'(got.at_start));
          if (got.accepting != want.accepting)
            flag("accepting", nbs_pkg::SET_W'(want.accepting),
                 nbs_pkg::SET_W'(got.accepting));
        end
      end
      if (items.valid && items.ready)
        pending_reports.push_back(apply_item(items.action, items.backward,
                                             items.source_state, items.symbol,
                                             items.row_mask));
      queued = pending_reports.size();
    end
  end

endmodule

`default_nettype wire

[bench/nfa_bitset_step_engine_tb.sv]
`default_nettype none

module nfa_bitset_step_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nbs_pkg::*;

  // Spare action code: the block must leave the set alone and report it.
  localparam logic [ACT_W-1:0] ACT_IDLE = 2'd3;

  localparam int ITEM_TARGET = 1220;    // directed plus random items
  localparam int CALM_TAIL   = 200;     // last stretch runs without idling
  localparam int LONG_HOLD   = 300;     // result side hold-off, in cycles
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic long_hold = 1'b0;
  int   mismatches;
  int   backlog;

  nbs_in_if  items_if ();
  nbs_out_if results_if ();
  nbs_cfg_if cfg_if ();

  nfa_bitset_step_engine dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  nbs_step_checker nfa_watch (
    .clk        (clk),
    .rst        (rst),
    .items      (items_if),
    .results    (results_if),
    .cfg        (cfg_if),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("nfa_bitset_step_engine: mismatch");
    $finish;
  end

  // Result side: stall in random bursts, or hold off for one long stretch
  // on request so the pipeline fills and pushes back on items.
  initial begin
    int n;
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        results_if.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 19);
        results_if.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        results_if.ready = 1'b1;
      end
    end
  end

  // Offer one item beat, with a random idle burst ahead of it when pacing
  // asks for one; return at the edge that takes it.
  task automatic offer_item(
    input logic [ACT_W-1:0] act,
    input logic             bwd,
    input logic [SRC_W-1:0] src,
    input logic [SYM_W-1:0] sym,
    input logic [SET_W-1:0] mask
  );
    int n;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 19);
      @(negedge clk);
      items_if.valid    = 1'b0;
      items_if.row_mask = SET_W'($urandom);   // junk while idle
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    items_if.valid        = 1'b1;
    items_if.action       = act;
    items_if.backward     = bwd;
    items_if.source_state = src;
    items_if.symbol       = sym;
    items_if.row_mask     = mask;
    do @(posedge clk); while (!items_if.ready);
    items_sent++;
  endtask

  // Write one register; only called while the block is idle.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [SET_W-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Drop valid, wait for every predicted result, then let the pipe empty.
  task automatic settle();
    @(negedge clk);
    items_if.valid = 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly sparse masks so steps neither die out nor saturate at once.
  function automatic logic [SET_W-1:0] pick_mask();
    logic [SET_W-1:0] m;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      m = '0;
      m[$urandom_range(0, SET_W - 1)] = 1'b1;
      m[$urandom_range(0, SET_W - 1)] = 1'b1;
    end else if (roll < 8) begin
      m = SET_W'($urandom);
    end else if (roll == 8) begin
      m = '1;
    end else begin
      m = '0;
    end
    return m;
  endfunction

  initial begin
    logic [SYM_W-1:0] alphabet [4];
    logic [SRC_W-1:0] start_val;
    logic [SET_W-1:0] accept_val;
    int               phase;
    int               roll;

    items_if.valid        = 1'b0;
    items_if.action       = ACT_WRITE;
    items_if.backward     = 1'b0;
    items_if.source_state = '0;
    items_if.symbol       = '0;
    items_if.row_mask     = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_START_STATE;
    cfg_if.data           = '0;

    // Hold reset, then release it on a falling edge.
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Registers are taken during the store sweep; items wait on ready.
    set_register(REG_START_STATE, SET_W'(15));
    set_register(REG_ACCEPT_MASK, 16'h8001);

    // Directed part: extreme states and symbols, both tables, every action.
    offer_item(ACT_STEP,  1'b0, 4'd0,  7'd0,   16'hFFFF);  // step on empty set
    offer_item(ACT_WRITE, 1'b0, 4'd0,  7'd0,   16'hFFFF);
    offer_item(ACT_WRITE, 1'b1, 4'd15, 7'd127, 16'h0001);
    offer_item(ACT_WRITE, 1'b0, 4'd15, 7'd127, 16'h8000);
    offer_item(ACT_WRITE, 1'b1, 4'd0,  7'd127, 16'h7FFE);
    offer_item(ACT_LOAD,  1'b0, 4'd0,  7'd0,   16'hFFFF);
    offer_item(ACT_STEP,  1'b0, 4'd0,  7'd127, 16'h0000);
    offer_item(ACT_STEP,  1'b0, 4'd0,  7'd127, 16'h0000);
    offer_item(ACT_STEP,  1'b1, 4'd0,  7'd127, 16'h0000);
    offer_item(ACT_STEP,  1'b1, 4'd0,  7'd127, 16'h0000);
    offer_item(ACT_STEP,  1'b1, 4'd0,  7'd0,   16'h0000);  // no backward row
    offer_item(ACT_LOAD,  1'b0, 4'd0,  7'd0,   16'h0001);
    offer_item(ACT_STEP,  1'b0, 4'd0,  7'd0,   16'h0000);  // fan out to all
    offer_item(ACT_IDLE,  1'b1, 4'd15, 7'd127, 16'hFFFF);  // spare code
    offer_item(ACT_WRITE, 1'b0, 4'd0,  7'd0,   16'h0000);  // overwrite a row
    offer_item(ACT_STEP,  1'b0, 4'd0,  7'd0,   16'h0000);
    offer_item(ACT_LOAD,  1'b0, 4'd0,  7'd0,   16'h0001);
    // Step right behind the write of the row it reads.
    offer_item(ACT_WRITE, 1'b0, 4'd0,  7'h55,  16'hA5A5);
    offer_item(ACT_STEP,  1'b0, 4'd0,  7'h55,  16'h0000);
    offer_item(ACT_WRITE, 1'b1, 4'd15, 7'h2A,  16'h5A5A);
    offer_item(ACT_STEP,  1'b1, 4'd0,  7'h2A,  16'h0000);
    offer_item(ACT_STEP,  1'b1, 4'd0,  7'h2A,  16'h0000);
    offer_item(ACT_LOAD,  1'b0, 4'd0,  7'd0,   16'h0000);
    offer_item(ACT_IDLE,  1'b0, 4'd0,  7'd0,   16'h0000);

    // Random part: each phase drains, picks new registers and pacing, builds
    // a small automaton over a four-symbol alphabet and runs text through it.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();

      start_val = (phase == 0) ? SRC_W'(0) :
                  (phase == 1) ? SRC_W'(15) : SRC_W'($urandom_range(0, 15));
      case (phase % 4)
        0: accept_val = 16'h0000;
        1: accept_val = 16'hFFFF;
        2: accept_val = SET_W'($urandom);
        default: accept_val = SET_W'(1) << start_val;
      endcase
      set_register(REG_START_STATE, SET_W'(start_val));
      set_register(REG_ACCEPT_MASK, accept_val);

      if (items_sent >= ITEM_TARGET - CALM_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 15 * $urandom_range(0, 2);
        stall_pct = 15 * $urandom_range(0, 2);
      end
      // Once, hold results off while items keep coming.
      if (phase == 2) long_hold = 1'b1;

      for (int k = 0; k < 4; k++) alphabet[k] = SYM_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        alphabet[0] = '0;
        alphabet[3] = '1;
      end

      repeat ($urandom_range(8, 24))
        offer_item(ACT_WRITE, $urandom_range(0, 3) == 0, SRC_W'($urandom),
                   alphabet[$urandom_range(0, 3)], pick_mask());
      offer_item(ACT_LOAD, 1'($urandom), SRC_W'($urandom), SYM_W'($urandom),
                 pick_mask());

      repeat ($urandom_range(20, 60)) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          offer_item(ACT_STEP, $urandom_range(0, 3) == 0, SRC_W'($urandom),
                     alphabet[$urandom_range(0, 3)], SET_W'($urandom));
        end else if (roll < 78) begin
          offer_item(ACT_LOAD, 1'($urandom), SRC_W'($urandom), SYM_W'($urandom),
                     pick_mask());
        end else if (roll < 88) begin
          offer_item(ACT_WRITE, 1'($urandom), SRC_W'($urandom),
                     alphabet[$urandom_range(0, 3)], pick_mask());
        end else if (roll < 93) begin
          offer_item(ACT_IDLE, 1'($urandom), SRC_W'($urandom), SYM_W'($urandom),
                     SET_W'($urandom));
        end else begin
          // Noise: any action, any symbol, any mask.
          offer_item(ACT_W'($urandom), 1'($urandom), SRC_W'($urandom),
                     SYM_W'($urandom), SET_W'($urandom));
        end
      end
      phase++;
    end

    // Drain and give the verdict.
    settle();
    if (mismatches == 0) begin
      $display("nfa_bitset_step_engine: match");
    end else begin
      $display("nfa_bitset_step_engine: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
